FILE: src/sas_pkg.sv
// Shared types and constants for the seek/arrive steering block.
package sas_pkg;

    localparam int FW   = 24;   // field width
    localparam int DW   = 25;   // offset width
    localparam int SQW  = 52;   // squared-length accumulator width
    localparam int MSW  = 23;   // max speed width
    localparam int RW   = 16;   // radius width
    localparam int CFGW = 23;   // config data width
    localparam int NUMW = 48;   // |d| * max_speed magnitude width
    localparam int DIVW = 26;   // divisor width

    localparam logic [0:0] REG_MAX_SPEED = 1'd0;
    localparam logic [0:0] REG_RADIUS    = 1'd1;

    localparam logic [MSW-1:0] MAX_SPEED_RESET = 23'd2560;
    localparam logic [RW-1:0]  RADIUS_RESET    = 16'd20;

    typedef struct packed {
        logic signed [FW-1:0] target_x;
        logic signed [FW-1:0] target_y;
        logic signed [FW-1:0] target_z;
        logic signed [FW-1:0] pos_x;
        logic signed [FW-1:0] pos_y;
        logic signed [FW-1:0] pos_z;
        logic signed [FW-1:0] vel_x;
        logic signed [FW-1:0] vel_y;
        logic signed [FW-1:0] vel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [FW-1:0] step_force_x;
        logic signed [FW-1:0] step_force_y;
        logic signed [FW-1:0] step_force_z;
        logic signed [FW-1:0] total_force_x;
        logic signed [FW-1:0] total_force_y;
        logic signed [FW-1:0] total_force_z;
    } t_out_item;

    function automatic logic signed [FW-1:0] sat24(input logic signed [FW+1:0] v);
        logic signed [FW-1:0] r;
        if (v > $signed({{2{1'b0}}, 1'b0, {(FW-1){1'b1}}})) r = {1'b0, {(FW-1){1'b1}}};
        else if (v < $signed({{2{1'b1}}, 1'b1, {(FW-1){1'b0}}})) r = {1'b1, {(FW-1){1'b0}}};
        else r = v[FW-1:0];
        return r;
    endfunction

endpackage

FILE: src/sas_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module sas_mul import sas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DW-1:0]   i_a,
    input  logic [DW-1:0]   i_b,
    output logic            o_done,
    output logic [2*DW-1:0] o_p
);
    logic [2*DW-1:0] r_acc, r_a;
    logic [DW-1:0]   r_b;
    logic [4:0]      r_cnt;
    logic            r_run, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DW-1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= {{DW{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_run) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a <= {r_a[2*DW-2:0], 1'b0};
            r_b <= {1'b0, r_b[DW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

FILE: src/sas_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module sas_sqrt import sas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQW-1:0]  i_v,
    output logic            o_done,
    output logic [DIVW-1:0] o_root
);
    logic [SQW-1:0]   r_v;
    logic [SQW+1:0]   r_rem;
    logic [DIVW-1:0]  r_root;
    logic [4:0]       r_cnt;
    logic             r_run, r_done;
    logic [SQW+1:0]   w_trial, w_rem2;

    assign w_rem2  = {r_rem[SQW-1:0], r_v[SQW-1:SQW-2]};
    assign w_trial = {{(SQW-DIVW){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIVW-1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_v <= {r_v[SQW-3:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[DIVW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[DIVW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: src/sas_div.sv
// Restoring divider, one quotient bit per cycle.
module sas_div import sas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DIVW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo
);
    logic [NUMW-1:0] r_q;
    logic [DIVW:0]   r_rem;
    logic [DIVW-1:0] r_den;
    logic [5:0]      r_cnt;
    logic            r_run, r_done;
    logic [DIVW:0]   w_sh;

    assign w_sh = {r_rem[DIVW-1:0], r_q[NUMW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NUMW-1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[NUMW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NUMW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

FILE: src/seek_arrive_steering.sv
// Seek with arrival: one steering force per item, accumulated with saturation.
// Per item: three serial squarings of the offset on the shared bit-serial multiplier,
// a serial square root, and for each axis a serial multiply by max_speed followed by
// a serial divide; then the output register is loaded. One item is in work at a time;
// the result sits in an output register and the next item can be taken the cycle after
// it is delivered.
module seek_arrive_steering import sas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in_item        i_item,
    output logic            o_valid,
    input  logic            i_ready,
    input  logic            i_cfg_we,
    input  logic [0:0]      i_cfg_index,
    input  logic [CFGW-1:0] i_cfg_data,
    output t_out_item       o_item
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_SQ = 9'b000000010, S_SQW = 9'b000000100,
        S_RT   = 9'b000001000, S_RTW = 9'b000010000, S_MUL = 9'b000100000,
        S_MULW = 9'b001000000, S_DIVW = 9'b010000000, S_OUT = 9'b100000000
    } t_state;

    t_state r_state;
    logic [MSW-1:0] r_max_speed;
    logic [RW-1:0]  r_radius;
    logic signed [DW-1:0] r_d [3];
    logic signed [FW-1:0] r_vel [3];
    logic signed [FW-1:0] r_acc [3];
    logic signed [FW-1:0] r_step [3];
    logic [SQW-1:0]  r_d2;
    logic [DIVW-1:0] r_den;
    logic [1:0]      r_ax;
    logic            r_ovalid;

    logic            w_mul_start, w_mul_done;
    logic            w_rt_start, w_rt_done;
    logic            w_dv_start, w_dv_done;
    logic [DW-1:0]   w_mul_a, w_mul_b, w_abs;
    logic [2*DW-1:0] w_prod;
    logic [DIVW-1:0] w_root;
    logic [NUMW-1:0] w_quo;
    logic [DIVW-1:0] w_rq;
    logic [SQW-1:0]  w_rq2;
    logic signed [DW-1:0] w_des;
    logic signed [FW+1:0] w_st, w_tot;
    logic signed [FW-1:0] w_stsat;

    assign w_abs   = r_d[r_ax][DW-1] ? DW'(-r_d[r_ax]) : r_d[r_ax];
    assign w_mul_a = w_abs;
    assign w_mul_b = (r_state == S_SQ) ? w_abs : {2'b00, r_max_speed};
    assign w_rq    = {2'b00, r_radius, 8'h00};
    // (radius * 256)^2 is radius^2 shifted up by 16
    assign w_rq2   = {4'h0, 32'(r_radius) * 32'(r_radius), 16'h0000};

    assign w_mul_start = (r_state == S_SQ) || (r_state == S_MUL);
    assign w_rt_start  = (r_state == S_RT);
    assign w_dv_start  = (r_state == S_MULW) && w_mul_done;

    sas_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mul_start), .i_a(w_mul_a),
        .i_b(w_mul_b), .o_done(w_mul_done), .o_p(w_prod));
    sas_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_rt_start), .i_v(r_d2),
        .o_done(w_rt_done), .o_root(w_root));
    sas_div u_div (.i_clk, .i_rst_n, .i_start(w_dv_start), .i_num(w_prod[NUMW-1:0]),
        .i_den(r_den), .o_done(w_dv_done), .o_quo(w_quo));

    assign w_des   = (r_d2 == '0) ? '0 :
                     (r_d[r_ax][DW-1] ? DW'(-w_quo[DW-1:0]) : w_quo[DW-1:0]);
    assign w_st    = (FW+2)'(w_des) - (FW+2)'(r_vel[r_ax]);
    assign w_stsat = sat24(w_st);
    assign w_tot   = (FW+2)'(r_acc[r_ax]) + (FW+2)'(w_stsat);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_speed <= MAX_SPEED_RESET;
            r_radius    <= RADIUS_RESET;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAX_SPEED: r_max_speed <= i_cfg_data[MSW-1:0];
                    REG_RADIUS:    r_radius    <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_d[0]   <= DW'(i_item.target_x) - DW'(i_item.pos_x);
                    r_d[1]   <= DW'(i_item.target_y) - DW'(i_item.pos_y);
                    r_d[2]   <= DW'(i_item.target_z) - DW'(i_item.pos_z);
                    r_vel[0] <= i_item.vel_x;
                    r_vel[1] <= i_item.vel_y;
                    r_vel[2] <= i_item.vel_z;
                    r_d2     <= '0;
                    r_ax     <= 2'd0;
                    r_state  <= S_SQ;
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: if (w_mul_done) begin
                    r_d2 <= r_d2 + SQW'(w_prod);
                    if (r_ax == 2'd2) begin
                        r_ax    <= 2'd0;
                        r_state <= S_RT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_RT: r_state <= S_RTW;
                S_RTW: if (w_rt_done) begin
                    r_den   <= (r_d2 <= w_rq2) ? w_rq : w_root;
                    r_state <= S_MUL;
                end
                S_MUL:  r_state <= S_MULW;
                S_MULW: if (w_mul_done) r_state <= S_DIVW;
                S_DIVW: if (w_dv_done) begin
                    r_step[r_ax] <= w_stsat;
                    r_acc[r_ax]  <= sat24(w_tot);
                    if (r_ax == 2'd2) r_state <= S_OUT;
                    else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_item.step_force_x  = r_step[0];
    assign o_item.step_force_y  = r_step[1];
    assign o_item.step_force_z  = r_step[2];
    assign o_item.total_force_x = r_acc[0];
    assign o_item.total_force_y = r_acc[1];
    assign o_item.total_force_z = r_acc[2];
endmodule

FILE: src/sas_checker.sv
// Port-level checks for the steering block, bound to the top level.
module sas_checker import sas_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result dropped or changed while stalled");
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result is pending");
    a_accept_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid && !o_ready)
        else $error("result appeared right after accept");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind seek_arrive_steering sas_checker u_sas_checker (.i_clk, .i_rst_n, .i_valid,
    .o_ready, .o_valid, .i_ready, .o_item);

FILE: bench/tb_seek_arrive_steering.sv
// Self-checking bench for the seek/arrive steering block with a built-in force predictor.
`timescale 1ns / 1ps

module tb_seek_arrive_steering;
    import sas_pkg::*;

    localparam longint SAT_HI = 8388607;
    localparam longint SAT_LO = -8388608;
    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     DRAIN_CYCLES = 400;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    t_in_item        i_item;
    logic            o_valid;
    logic            i_ready;
    logic            i_cfg_we;
    logic [0:0]      i_cfg_index;
    logic [CFGW-1:0] i_cfg_data;
    t_out_item       o_item;

    seek_arrive_steering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_item      (o_item)
    );

    // predictor state
    longint    model_speed;
    longint    model_radius;
    longint    model_acc [3];
    t_out_item expected_forces [$];

    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_request;
    int  hold_left;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic longint sat_force(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic t_out_item predict_steering(t_in_item it);
        longint    d [3];
        longint    vel [3];
        longint    desired [3];
        longint    d2;
        longint    rq;
        longint    divisor;
        longint    step;
        longint    total;
        t_out_item r;
        d[0] = longint'(it.target_x) - longint'(it.pos_x);
        d[1] = longint'(it.target_y) - longint'(it.pos_y);
        d[2] = longint'(it.target_z) - longint'(it.pos_z);
        vel[0] = longint'(it.vel_x);
        vel[1] = longint'(it.vel_y);
        vel[2] = longint'(it.vel_z);
        d2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        for (int i = 0; i < 3; i++) desired[i] = 0;
        if (d2 != 0) begin
            rq = model_radius * 256;
            divisor = (d2 <= rq * rq) ? rq : floor_sqrt(d2);
            for (int i = 0; i < 3; i++) desired[i] = (d[i] * model_speed) / divisor;
        end
        for (int i = 0; i < 3; i++) begin
            step = sat_force(desired[i] - vel[i]);
            total = sat_force(model_acc[i] + step);
            model_acc[i] = total;
            case (i)
                0: begin r.step_force_x = step[23:0]; r.total_force_x = total[23:0]; end
                1: begin r.step_force_y = step[23:0]; r.total_force_y = total[23:0]; end
                default: begin
                    r.step_force_z = step[23:0];
                    r.total_force_z = total[23:0];
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t %s expected %0d actual %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_forces.size() == 0) begin
                error_count++;
                $display("%0t unexpected result, expected none actual %h", $time, o_item);
            end else begin
                e = expected_forces.pop_front();
                check_field("step_force_x", e.step_force_x, o_item.step_force_x);
                check_field("step_force_y", e.step_force_y, o_item.step_force_y);
                check_field("step_force_z", e.step_force_z, o_item.step_force_z);
                check_field("total_force_x", e.total_force_x, o_item.total_force_x);
                check_field("total_force_y", e.total_force_y, o_item.total_force_y);
                check_field("total_force_z", e.total_force_z, o_item.total_force_z);
            end
        end
    end

    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        expected_forces.push_back(predict_steering(it));
    endtask

    // drop valid and wait for every pending item to come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFGW-1:0] speed, logic [RW-1:0] radius);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_SPEED;
        i_cfg_data  <= speed;
        @(posedge i_clk);
        i_cfg_index <= REG_RADIUS;
        i_cfg_data  <= CFGW'(radius);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_speed  = longint'(speed);
        model_radius = longint'(radius);
    endtask

    function automatic t_in_item make_item(logic [23:0] tx, logic [23:0] ty,
                                           logic [23:0] tz, logic [23:0] px,
                                           logic [23:0] py, logic [23:0] pz,
                                           logic [23:0] vx, logic [23:0] vy,
                                           logic [23:0] vz);
        t_in_item it;
        it.target_x = tx; it.target_y = ty; it.target_z = tz;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
        return it;
    endfunction

    // mostly targets near the agent, some anywhere
    function automatic t_in_item random_item();
        t_in_item    it;
        logic [23:0] span;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(3) != 0) begin
            span = 24'($urandom) >> $urandom_range(23, 8);
            it.target_x = it.pos_x + (24'($urandom) & span) - (span >> 1);
            it.target_y = it.pos_y + (24'($urandom) & span) - (span >> 1);
            it.target_z = it.pos_z + (24'($urandom) & span) - (span >> 1);
            if ($urandom_range(1)) begin
                it.vel_x = 24'($signed(24'($urandom)) >>> 12);
                it.vel_y = 24'($signed(24'($urandom)) >>> 12);
                it.vel_z = 24'($signed(24'($urandom)) >>> 12);
            end
        end
        return it;
    endfunction

    task automatic test_directed();
        logic [23:0] mx;
        logic [23:0] mn;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        // zero distance, default registers
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(100, -5, 7, 100, -5, 7, 300, -300, 1));
        // inside and outside the default radius
        send_item(make_item(256, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(5120, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(5121, 3, -2, 0, 0, 0, 10, 20, 30));
        send_item(make_item(1, 1, 1, 0, 0, 0, 0, 0, 0));
        // widest offsets and velocity extremes
        send_item(make_item(mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_item(make_item(mn, mn, mn, mx, mx, mx, mn, mn, mn));
        send_item(make_item(mx, mn, 0, mn, mx, 0, mn, mx, 0));
        // push the totals into saturation
        repeat (4) send_item(make_item(0, 0, 0, 0, 0, 0, mn, mx, mn));
        repeat (4) send_item(make_item(0, 0, 0, 0, 0, 0, mx, mn, mx));
        write_config(23'h7FFFFF, 16'd0);
        send_item(make_item(mx, 0, 0, mn, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(1, 0, 0, 0, 0, 0, mx, 0, 0));
        write_config(23'd0, 16'hFFFF);
        send_item(make_item(mx, mn, 256, 0, 0, 0, 5, -5, 0));
        send_item(make_item(mn, mx, 0, mx, mn, 0, 0, 0, 0));
        write_config(23'h7FFFFF, 16'hFFFF);
        send_item(make_item(mx, mx, mx, mn, mn, mn, 0, 0, 0));
        send_item(make_item(1000, -1000, 0, 0, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_random_phase(int sidle, int ridle, int count);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 99) begin
                case ($urandom_range(4))
                    0: write_config(23'h7FFFFF, 16'($urandom));
                    1: write_config(23'($urandom), 16'd0);
                    2: write_config(23'($urandom_range(4096)), 16'hFFFF);
                    3: write_config(23'd0, 16'($urandom_range(64)));
                    default: write_config(23'($urandom), 16'($urandom_range(200)));
                endcase
            end
            send_item(random_item());
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 3000;
        for (int n = 0; n < 20; n++) send_item(random_item());
        drain_results();
        // sender pauses until everything is back, then resumes
        for (int n = 0; n < 10; n++) begin
            send_item(random_item());
            drain_results();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_MAX_SPEED;
        i_cfg_data  <= '0;
        cycle_count = 0;
        error_count = 0;
        hold_request = 0;
        hold_left = 0;
        send_idle_pct = 11;
        recv_idle_pct = 56;
        model_speed  = 2560;
        model_radius = 20;
        for (int i = 0; i < 3; i++) model_acc[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(11, 56, 400);
        test_random_phase(56, 11, 400);
        test_random_phase(0, 0, 400);
        test_backpressure();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_forces.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
